// ----- design/tet_pkg.sv -----
// ---------------------------------------------------------------------------
// tet_pkg: shared definitions for the tagged expiry table
// Operation and status codes, field widths and parameter defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tet_pkg;

    // Field widths of the transaction ports
    localparam int OP_W     = 2;
    localparam int TAG_IN_W = 16;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;

    // Parameter defaults
    localparam int DEF_ENTRIES   = 16;
    localparam int DEF_TAG_WIDTH = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SET   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_VALID     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd4;

endpackage

`default_nettype wire

// ----- design/tet_mem.sv -----
// ---------------------------------------------------------------------------
// tet_mem: entry store of tag and deadline
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tet_mem #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 48
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/tet_ctrl.sv -----
// ---------------------------------------------------------------------------
// tet_ctrl: scan sequencer of the tagged expiry table
// Walks the entry store one entry per cycle, except for a tick, then updates
// the entry, the used bits or the millisecond counter and loads the status output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tet_ctrl #(
    parameter int ENTRIES   = tet_pkg::DEF_ENTRIES,
    parameter int TAG_WIDTH = tet_pkg::DEF_TAG_WIDTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [tet_pkg::OP_W-1:0]      s_operation,
    input  wire logic [tet_pkg::TAG_IN_W-1:0]  s_tag,
    input  wire logic [tet_pkg::TIME_W-1:0]    s_duration,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [tet_pkg::STATUS_W-1:0]       m_status,
    output logic                               mem_wr_en,
    output logic [$clog2(ENTRIES)-1:0]         mem_wr_addr,
    output logic [TAG_WIDTH+tet_pkg::TIME_W-1:0] mem_wr_data,
    output logic                               mem_rd_en,
    output logic [$clog2(ENTRIES)-1:0]         mem_rd_addr,
    input  wire logic [TAG_WIDTH+tet_pkg::TIME_W-1:0] mem_rd_data
);

    import tet_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [ENTRIES-1:0]      used_reg, used_next;
    logic [TIME_W-1:0]       time_reg, time_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [TAG_WIDTH-1:0]    tag_reg, tag_next;
    logic [TIME_W-1:0]       dur_reg, dur_next;
    logic [CNT_W-1:0]        scan_cnt_reg, scan_cnt_next;
    logic                    cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                    hit_reg, hit_next;
    logic [IDX_W-1:0]        hit_idx_reg, hit_idx_next;
    logic [TIME_W-1:0]       hit_dl_reg, hit_dl_next;
    logic                    free_found_reg, free_found_next;
    logic [IDX_W-1:0]        free_idx_reg, free_idx_next;
    logic [STATUS_W-1:0]     result_reg, result_next;
    logic                    m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]     m_status_reg, m_status_next;

    logic [TAG_WIDTH-1:0]    rd_tag;
    logic [TIME_W-1:0]       rd_dl;
    logic [IDX_W-1:0]        issue_idx;
    logic                    issue_live;
    logic                    cmp_match;

    assign rd_tag     = mem_rd_data[TAG_WIDTH+TIME_W-1:TIME_W];
    assign rd_dl      = mem_rd_data[TIME_W-1:0];
    assign issue_idx  = scan_cnt_reg[IDX_W-1:0];
    assign issue_live = (scan_cnt_reg < CNT_W'(ENTRIES));
    assign cmp_match  = cmp_valid_reg && used_reg[cmp_idx_reg] && (rd_tag == tag_reg);

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;

    // Sequence one transaction: scan, execute, respond (a tick goes straight to respond)
    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        time_next       = time_reg;
        op_next         = op_reg;
        tag_next        = tag_reg;
        dur_next        = dur_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_dl_next     = hit_dl_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        result_next     = result_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = hit_idx_reg;
        mem_wr_data     = {tag_reg, dur_reg + time_reg};
        mem_rd_en       = 1'b0;
        mem_rd_addr     = issue_idx;

        // Drop the result once the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next         = s_operation;
                    tag_next        = TAG_WIDTH'(s_tag);
                    dur_next        = s_duration;
                    scan_cnt_next   = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    if (s_operation == OP_TICK) begin
                        time_next   = time_reg + TIME_W'(1);
                        result_next = ST_OK;
                        state_next  = S_RESP;
                    end else begin
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Issue the next read and note the lowest free entry
                if (issue_live) begin
                    mem_rd_en      = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_idx;
                    scan_cnt_next  = scan_cnt_reg + CNT_W'(1);
                    if (!used_reg[issue_idx] && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = issue_idx;
                    end
                end
                // Compare the entry read in the previous cycle
                if (cmp_match) begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    hit_dl_next  = rd_dl;
                    state_next   = S_EXEC;
                end else if (cmp_valid_reg && cmp_idx_reg == IDX_W'(ENTRIES - 1)) begin
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_RESP;
                case (op_reg)
                    OP_SET: begin
                        if (hit_reg) begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = hit_idx_reg;
                            result_next = ST_OK;
                        end else if (free_found_reg) begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = free_idx_reg;
                            used_next[free_idx_reg] = 1'b1;
                            result_next = ST_OK;
                        end else begin
                            result_next = ST_FULL;
                        end
                    end
                    OP_CLEAR: begin
                        if (hit_reg) begin
                            used_next[hit_idx_reg] = 1'b0;
                            result_next = ST_OK;
                        end else begin
                            result_next = ST_NOT_FOUND;
                        end
                    end
                    OP_QUERY: begin
                        if (!hit_reg) begin
                            result_next = ST_NOT_FOUND;
                        end else if (hit_dl_reg > time_reg) begin
                            result_next = ST_VALID;
                        end else begin
                            result_next = ST_EXPIRED;
                        end
                    end
                    default: begin
                        result_next = ST_OK;
                    end
                endcase
            end
            S_RESP: begin
                // Load the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = result_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            time_reg      <= '0;
            m_valid_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            time_reg      <= time_next;
            m_valid_reg   <= m_valid_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    // Payload and scan bookkeeping
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        tag_reg        <= tag_next;
        dur_reg        <= dur_next;
        scan_cnt_reg   <= scan_cnt_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_dl_reg     <= hit_dl_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        result_reg     <= result_next;
        m_status_reg   <= m_status_next;
    end

endmodule

`default_nettype wire

// ----- design/tagged_expiry_table.sv -----
// ---------------------------------------------------------------------------
// tagged_expiry_table: tag-keyed expiry deadlines with a millisecond counter
//
// Input channel (s_valid/s_ready): one transaction carries an operation
// (set, clear, query, tick), a tag and a duration. Result channel
// (m_valid/m_ready): exactly one 3-bit status per input transaction, in order.
// Set, clear and query scan the entry store one entry per cycle through its
// single read port, then execute and respond; the scan ends early when the
// tag is found. A tick steps the counter and responds without a scan. One
// transaction is in work at a time; the status sits in an output register,
// so the next transaction is taken while it waits. A stalled receiver holds
// the status; a finished transaction then waits for the output register
// before the block takes another.
// Reset clears the used bits (table empty), the counter and the output
// valid; the entry store itself needs no clearing pass.
// Writes land in the execute step, before any read of the next transaction,
// so store accesses never overlap.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tagged_expiry_table #(
    parameter int ENTRIES   = tet_pkg::DEF_ENTRIES,
    parameter int TAG_WIDTH = tet_pkg::DEF_TAG_WIDTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [tet_pkg::OP_W-1:0]     s_operation,
    input  wire logic [tet_pkg::TAG_IN_W-1:0] s_tag,
    input  wire logic [tet_pkg::TIME_W-1:0]   s_duration,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [tet_pkg::STATUS_W-1:0]      m_status
);

    import tet_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int DATA_W = TAG_WIDTH + TIME_W;

    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    logic [DATA_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_rd_addr;
    logic [DATA_W-1:0] mem_rd_data;

    // Scan sequencer, used bits and counter
    tet_ctrl #(
        .ENTRIES   (ENTRIES),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_tag       (s_tag),
        .s_duration  (s_duration),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // Entry store of tag and deadline
    tet_mem #(
        .DEPTH  (ENTRIES),
        .DATA_W (DATA_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire

// ----- verif/tb_tagged_expiry_table.sv -----
// ---------------------------------------------------------------------------
// tb_tagged_expiry_table: self-checking testbench for the tagged expiry table
// Drives set, clear, query and tick transactions through the valid/ready
// input channel. A behavioral table model predicts every status the script
// leaves open, and each returned status is checked in order. A directed
// script covers the corners, then random traffic on a small pool of tags
// follows, with random idling on both channels and one long receiver hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tagged_expiry_table;

    import tet_pkg::*;

    localparam int          NUM_ENTRIES   = DEF_ENTRIES;
    localparam logic [15:0] TAG_KEY_MASK  = 16'((33'h1 << DEF_TAG_WIDTH) - 1);
    localparam int          RANDOM_ITEMS  = 1400;
    localparam int          QUIET_ITEMS   = 200;
    localparam int          POOL_SIZE     = 20;
    localparam int          HOLD_AT       = 300;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          DRAIN_CYCLES  = 4 * (NUM_ENTRIES + 4);
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SCRIPT_ROWS   = 19;

    // One row of the directed script; count > 1 repeats a set on tag, tag+1, ...
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [TAG_IN_W-1:0] tag;
        logic [TIME_W-1:0]   dur;
        logic [7:0]          count;
        logic                typed;
        logic [STATUS_W-1:0] status;
    } script_row_t;

    localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
        '{OP_QUERY, 16'h0000, 32'h0000_0000, 8'd1,  1'b1, ST_NOT_FOUND},
        '{OP_CLEAR, 16'hFFFF, 32'h0000_0000, 8'd1,  1'b1, ST_NOT_FOUND},
        '{OP_TICK,  16'h1234, 32'hFFFF_FFFF, 8'd1,  1'b1, ST_OK},
        '{OP_SET,   16'h0000, 32'h0000_0000, 8'd1,  1'b1, ST_OK},
        '{OP_QUERY, 16'h0000, 32'h0000_0000, 8'd1,  1'b1, ST_EXPIRED},
        '{OP_SET,   16'hFFFF, 32'hFFFF_FFFF, 8'd1,  1'b1, ST_OK},
        '{OP_QUERY, 16'hFFFF, 32'h0000_0000, 8'd1,  1'b1, ST_EXPIRED},
        '{OP_SET,   16'h0000, 32'h0000_0005, 8'd1,  1'b1, ST_OK},
        '{OP_QUERY, 16'h0000, 32'hFFFF_FFFF, 8'd1,  1'b1, ST_VALID},
        '{OP_SET,   16'h0100, 32'h8000_0000, 8'd14, 1'b0, ST_OK},
        '{OP_SET,   16'h5555, 32'h0000_0001, 8'd1,  1'b1, ST_FULL},
        '{OP_QUERY, 16'h5555, 32'h0000_0000, 8'd1,  1'b1, ST_NOT_FOUND},
        '{OP_CLEAR, 16'h0105, 32'h0000_0000, 8'd1,  1'b1, ST_OK},
        '{OP_SET,   16'hAAAA, 32'h0000_1234, 8'd1,  1'b0, ST_OK},
        '{OP_QUERY, 16'hAAAA, 32'h0000_0000, 8'd1,  1'b0, ST_OK},
        '{OP_QUERY, 16'h0108, 32'h0000_0000, 8'd1,  1'b0, ST_OK},
        '{OP_CLEAR, 16'h0000, 32'h0000_0000, 8'd1,  1'b1, ST_OK},
        '{OP_QUERY, 16'h0000, 32'h0000_0000, 8'd1,  1'b1, ST_NOT_FOUND},
        '{OP_TICK,  16'h0000, 32'h0000_0000, 8'd1,  1'b1, ST_OK}
    };

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation;
    logic [TAG_IN_W-1:0] s_tag;
    logic [TIME_W-1:0]   s_duration;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;

    // Shadow copy of the table and the millisecond counter
    logic                model_used     [NUM_ENTRIES];
    logic [TAG_IN_W-1:0] model_tag      [NUM_ENTRIES];
    logic [TIME_W-1:0]   model_deadline [NUM_ENTRIES];
    logic [TIME_W-1:0]   model_now;

    logic [STATUS_W-1:0] pending_status [$];
    logic [TAG_IN_W-1:0] tag_pool [POOL_SIZE];
    int                  fail_count;
    int                  accepted_items;
    int                  cycle_count;
    bit                  quiet;
    bit                  hold_done;

    tagged_expiry_table dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_tag       (s_tag),
        .s_duration  (s_duration),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status)
    );

    // Apply one operation to the shadow table and return its status
    function automatic logic [STATUS_W-1:0] apply_expiry_op(
        input logic [OP_W-1:0]     op,
        input logic [TAG_IN_W-1:0] tag,
        input logic [TIME_W-1:0]   dur
    );
        logic [TAG_IN_W-1:0] key;
        int                  hit;
        int                  free_slot;
        key       = tag & TAG_KEY_MASK;
        hit       = -1;
        free_slot = -1;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (model_used[i] && model_tag[i] == key) hit = i;
            if (!model_used[i]) free_slot = i;
        end
        case (op)
            OP_SET: begin
                if (hit < 0) hit = free_slot;
                if (hit < 0) return ST_FULL;
                model_used[hit]     = 1'b1;
                model_tag[hit]      = key;
                model_deadline[hit] = dur + model_now;
                return ST_OK;
            end
            OP_CLEAR: begin
                if (hit < 0) return ST_NOT_FOUND;
                model_used[hit] = 1'b0;
                return ST_OK;
            end
            OP_QUERY: begin
                if (hit < 0) return ST_NOT_FOUND;
                return (model_deadline[hit] > model_now) ? ST_VALID : ST_EXPIRED;
            end
            default: begin
                model_now = model_now + 1;
                return ST_OK;
            end
        endcase
    endfunction

    // Offer one transaction, hold it until accepted, then queue its status
    task automatic send_item(
        input logic [OP_W-1:0]     op,
        input logic [TAG_IN_W-1:0] tag,
        input logic [TIME_W-1:0]   dur,
        input bit                  typed,
        input logic [STATUS_W-1:0] typed_status
    );
        logic [STATUS_W-1:0] predicted;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_tag       <= tag;
        s_duration  <= dur;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_expiry_op(op, tag, dur);
        pending_status.push_back(typed ? typed_status : predicted);
        accepted_items++;
        @(negedge aclk);
    endtask

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d statuses outstanding", $time,
                     pending_status.size());
            $display("tb_tagged_expiry_table: FAIL");
            $finish;
        end
    end

    // Check every returned status against the oldest prediction
    always @(posedge aclk) begin : check_status
        logic [STATUS_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                $display("%0t: status %0d returned with no transaction outstanding",
                         $time, m_status);
                fail_count++;
            end else begin
                want = pending_status.pop_front();
                if (m_status !== want) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want, m_status);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random ready bursts, one long hold-off to back up the input
    initial begin : receiver
        int span;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (!hold_done && accepted_items >= HOLD_AT) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end else if (quiet || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                span = quiet ? 1 : $urandom_range(1, 10);
                repeat (span) @(negedge aclk);
            end else begin
                m_ready <= 1'b0;
                span = $urandom_range(1, 10);
                repeat (span) @(negedge aclk);
            end
        end
    end

    // Sender: reset, directed script, random traffic, drain
    initial begin : sender
        logic [OP_W-1:0]     op;
        logic [TAG_IN_W-1:0] tag;
        logic [TIME_W-1:0]   dur;
        int                  pick;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_operation    = OP_TICK;
        s_tag          = '0;
        s_duration     = '0;
        fail_count     = 0;
        accepted_items = 0;
        cycle_count    = 0;
        quiet          = 1'b0;
        hold_done      = 1'b0;
        model_now      = '0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            model_used[i]     = 1'b0;
            model_tag[i]      = '0;
            model_deadline[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++) tag_pool[i] = 16'($urandom);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Walk the directed script
        for (int r = 0; r < SCRIPT_ROWS; r++) begin
            for (int k = 0; k < int'(SCRIPT[r].count); k++) begin
                send_item(SCRIPT[r].op, SCRIPT[r].tag + TAG_IN_W'(k), SCRIPT[r].dur,
                          SCRIPT[r].typed, SCRIPT[r].status);
            end
        end

        // Random traffic: mostly pooled tags and short durations so that
        // sets, queries and ticks interact; some fully random fields
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 35)      op = OP_SET;
            else if (pick < 52) op = OP_CLEAR;
            else if (pick < 77) op = OP_QUERY;
            else                op = OP_TICK;
            tag = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                               : tag_pool[$urandom_range(0, POOL_SIZE - 1)];
            pick = $urandom_range(0, 9);
            if (pick < 7)       dur = 32'($urandom_range(0, 30));
            else if (pick < 9)  dur = $urandom;
            else                dur = 32'hFFFF_FFFF - 32'($urandom_range(0, 30));
            send_item(op, tag, dur, 1'b0, ST_OK);
        end
        s_valid <= 1'b0;

        // Drain outstanding statuses, then let the block settle
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_tagged_expiry_table: PASS");
        end else begin
            $display("tb_tagged_expiry_table: FAIL");
        end
        $finish;
    end

endmodule

// ----- tagged_expiry_table.f -----
design/tet_pkg.sv
design/tet_mem.sv
design/tet_ctrl.sv
design/tagged_expiry_table.sv
verif/tb_tagged_expiry_table.sv
